>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL of the lane reduction block.
// Each macro expands to one labeled concurrent assertion on clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while rst is low.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked also during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> rtl/ncrl_pkg.sv
// Types and constants of the lane reduction block.
// Used by noc_collective_reduction_lanes_core; depends on nothing.
`default_nettype none

package ncrl_pkg;

  localparam int LANES = 4;

  localparam logic [2:0] CMD_UNKNOWN = 3'd0;
  localparam logic [2:0] CMD_PASS    = 3'd1;
  localparam logic [2:0] CMD_UADD    = 3'd2;
  localparam logic [2:0] CMD_SADD    = 3'd3;
  localparam logic [2:0] CMD_FADD    = 3'd4;
  localparam logic [2:0] CMD_UMAX    = 3'd5;
  localparam logic [2:0] CMD_SMAX    = 3'd6;
  localparam logic [2:0] CMD_FMAX    = 3'd7;

  // Fixed-point width of a widened fp16 sum, in units of 2^-24.
  localparam int MAG_W = 43;
  localparam int POS_W = 6;

  localparam logic [14:0] HALF_INF = 15'h7C00;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [15:0] acc_lane0;
    logic [15:0] acc_lane1;
    logic [15:0] acc_lane2;
    logic [15:0] acc_lane3;
    logic [15:0] child_lane0;
    logic [15:0] child_lane1;
    logic [15:0] child_lane2;
    logic [15:0] child_lane3;
  } ncrl_req_t;

  typedef struct packed {
    logic [15:0] res_lane0;
    logic [15:0] res_lane1;
    logic [15:0] res_lane2;
    logic [15:0] res_lane3;
    logic        unknown_op;
  } ncrl_res_t;

endpackage

`default_nettype wire

>>> rtl/noc_collective_reduction_lanes_core.sv
// Lane-wise reduction of an accumulator vector with a child vector.
// Depends on ncrl_pkg and assert_macros.svh.
//
// Usage: a request on req (req_valid/req_ready) carries cmd and four
// accumulator and four child lanes. The result leaves on res
// (res_valid/res_ready) with four combined lanes and unknown_op.
// Operations: pass, wrapping add, unsigned and signed max, fp16 add and
// fp16 max; ties pick the child.
// The datapath is four register stages (widen and integer ops, signed
// add, leading-one search, single-precision rounding) followed by the
// output register, which narrows to fp16 at its input.
// Throughput is one request per cycle while not stalled; the whole
// pipeline advances whenever the output register is empty or being taken.
// When the receiver stalls, every stage holds and req_ready drops, so
// nothing is lost or repeated.
// Reset (rst, synchronous) clears all valid bits; data registers are
// not reset.
`default_nettype none

`include "assert_macros.svh"

module noc_collective_reduction_lanes_core
  import ncrl_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      req_valid,
  output logic           req_ready,
  input  wire ncrl_req_t req,
  output logic           res_valid,
  input  wire logic      res_ready,
  output ncrl_res_t      res
);

  logic adv;
  assign adv = !res_valid || res_ready;
  assign req_ready = adv;

  logic [15:0] acc_in [LANES];
  logic [15:0] chd_in [LANES];
  assign acc_in[0] = req.acc_lane0;
  assign acc_in[1] = req.acc_lane1;
  assign acc_in[2] = req.acc_lane2;
  assign acc_in[3] = req.acc_lane3;
  assign chd_in[0] = req.child_lane0;
  assign chd_in[1] = req.child_lane1;
  assign chd_in[2] = req.child_lane2;
  assign chd_in[3] = req.child_lane3;

  // Stage registers. A lane with direct set already holds its final value.
  logic              v1, v2, v3, v4;
  logic              unk1, unk2, unk3, unk4;
  logic              dir1 [LANES];
  logic [15:0]       dval1 [LANES];
  logic              sa1 [LANES];
  logic              sc1 [LANES];
  logic [MAG_W-1:0]  na1 [LANES];
  logic [MAG_W-1:0]  nc1 [LANES];
  logic              dir2 [LANES];
  logic [15:0]       dval2 [LANES];
  logic              sg2 [LANES];
  logic [MAG_W-1:0]  mag2 [LANES];
  logic              dir3 [LANES];
  logic [15:0]       dval3 [LANES];
  logic              sg3 [LANES];
  logic [MAG_W-1:0]  mag3 [LANES];
  logic [POS_W-1:0]  pos3 [LANES];
  logic              dir4 [LANES];
  logic [15:0]       dval4 [LANES];
  logic              sg4 [LANES];
  logic [MAG_W-1:0]  mag4 [LANES];
  logic [POS_W-1:0]  pos4 [LANES];

  logic              dir1_next [LANES];
  logic [15:0]       dval1_next [LANES];
  logic [MAG_W-1:0]  na1_next [LANES];
  logic [MAG_W-1:0]  nc1_next [LANES];
  logic              dir2_next [LANES];
  logic [15:0]       dval2_next [LANES];
  logic              sg2_next [LANES];
  logic [MAG_W-1:0]  mag2_next [LANES];
  logic [POS_W-1:0]  pos3_next [LANES];
  logic [MAG_W-1:0]  mag4_next [LANES];
  logic [POS_W-1:0]  pos4_next [LANES];
  logic [15:0]       out_next [LANES];

  // Stage 1: integer operations, fp16 max, and widening for fp16 add.
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      logic [15:0] a, c, hm;
      logic signed [15:0] ka, kc;
      logic tiny_a, tiny_c;
      a = acc_in[l];
      c = chd_in[l];
      ka = (a[14:0] == 15'd0) ? 16'sd0 :
           (a[15] ? -$signed({1'b0, a[14:0]}) : $signed({1'b0, a[14:0]}));
      kc = (c[14:0] == 15'd0) ? 16'sd0 :
           (c[15] ? -$signed({1'b0, c[14:0]}) : $signed({1'b0, c[14:0]}));
      hm = (ka > kc) ? a : c;
      tiny_a = (a[14:10] == 5'd0);
      tiny_c = (c[14:10] == 5'd0);
      na1_next[l] = tiny_a ? '0 :
        ({{(MAG_W-11){1'b0}}, 1'b1, a[9:0]} << (a[14:10] - 5'd1));
      nc1_next[l] = tiny_c ? '0 :
        ({{(MAG_W-11){1'b0}}, 1'b1, c[9:0]} << (c[14:10] - 5'd1));
      dir1_next[l] = 1'b1;
      case (req.cmd)
        CMD_UADD, CMD_SADD: dval1_next[l] = a + c;
        CMD_UMAX: dval1_next[l] = (a > c) ? a : c;
        CMD_SMAX: dval1_next[l] = ($signed(a) > $signed(c)) ? a : c;
        CMD_FMAX: begin
          // Exponent zero narrows to signed zero, exponent 31 to infinity.
          if (hm[14:10] == 5'd0) dval1_next[l] = {hm[15], 15'd0};
          else if (hm[14:10] == 5'h1F) dval1_next[l] = {hm[15], HALF_INF};
          else dval1_next[l] = hm;
        end
        CMD_FADD: begin
          // Two tiny operands always narrow to a signed zero.
          dir1_next[l] = tiny_a && tiny_c;
          if (a[15] == c[15]) dval1_next[l] = {a[15], 15'd0};
          else if (a[9:0] > c[9:0]) dval1_next[l] = {a[15], 15'd0};
          else if (a[9:0] < c[9:0]) dval1_next[l] = {c[15], 15'd0};
          else dval1_next[l] = 16'd0;
        end
        default: dval1_next[l] = a;
      endcase
    end
  end

  // Stage 2: signed add of the fixed-point operands.
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      dir2_next[l] = dir1[l];
      dval2_next[l] = dval1[l];
      if (sa1[l] == sc1[l]) begin
        mag2_next[l] = na1[l] + nc1[l];
        sg2_next[l] = sa1[l];
      end else if (na1[l] > nc1[l]) begin
        mag2_next[l] = na1[l] - nc1[l];
        sg2_next[l] = sa1[l];
      end else begin
        mag2_next[l] = nc1[l] - na1[l];
        sg2_next[l] = sc1[l];
      end
      if (!dir1[l] && na1[l] == nc1[l] && sa1[l] != sc1[l]) begin
        dir2_next[l] = 1'b1;
        dval2_next[l] = 16'd0;
      end
    end
  end

  // Stage 3: position of the leading one.
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      pos3_next[l] = '0;
      for (int i = 0; i < MAG_W; i++) begin
        if (mag2[l][i]) pos3_next[l] = POS_W'(i);
      end
    end
  end

  // Stage 4: round to a 24-bit significand, nearest-even.
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      logic [POS_W-1:0] s;
      logic [MAG_W-1:0] mask, half, low, unit;
      logic up;
      s = pos3[l] - POS_W'(23);
      unit = {{(MAG_W-1){1'b0}}, 1'b1} << s;
      mask = unit - {{(MAG_W-1){1'b0}}, 1'b1};
      half = unit >> 1;
      low = mag3[l] & mask;
      up = (low > half) || (low == half && (mag3[l] & unit) != '0);
      if (pos3[l] >= POS_W'(24)) begin
        mag4_next[l] = (mag3[l] & ~mask) + (up ? unit : '0);
      end else begin
        mag4_next[l] = mag3[l];
      end
      pos4_next[l] = pos3[l];
      if (pos3[l] < POS_W'(MAG_W - 1) && mag4_next[l][pos3[l] + POS_W'(1)]) begin
        pos4_next[l] = pos3[l] + POS_W'(1);
      end
    end
  end

  // Narrowing to fp16 in front of the output register.
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      logic [POS_W-1:0] x;
      logic [MAG_W-1:0] sh;
      x = pos4[l] - POS_W'(9);
      sh = mag4[l] >> (pos4[l] - POS_W'(10));
      if (dir4[l]) out_next[l] = dval4[l];
      else if (pos4[l] >= POS_W'(40)) out_next[l] = {sg4[l], HALF_INF};
      else if (pos4[l] <= POS_W'(9)) out_next[l] = {sg4[l], 5'd0, mag4[l][9:0]};
      else out_next[l] = {sg4[l], x[4:0], sh[9:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      res_valid <= 1'b0;
    end else if (adv) begin
      v1 <= req_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      res_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      unk1 <= (req.cmd == CMD_UNKNOWN);
      unk2 <= unk1;
      unk3 <= unk2;
      unk4 <= unk3;
      res.unknown_op <= unk4;
      res.res_lane0 <= out_next[0];
      res.res_lane1 <= out_next[1];
      res.res_lane2 <= out_next[2];
      res.res_lane3 <= out_next[3];
      for (int l = 0; l < LANES; l++) begin
        dir1[l] <= dir1_next[l];
        dval1[l] <= dval1_next[l];
        sa1[l] <= acc_in[l][15];
        sc1[l] <= chd_in[l][15];
        na1[l] <= na1_next[l];
        nc1[l] <= nc1_next[l];
        dir2[l] <= dir2_next[l];
        dval2[l] <= dval2_next[l];
        sg2[l] <= sg2_next[l];
        mag2[l] <= mag2_next[l];
        dir3[l] <= dir2[l];
        dval3[l] <= dval2[l];
        sg3[l] <= sg2[l];
        mag3[l] <= mag2[l];
        pos3[l] <= pos3_next[l];
        dir4[l] <= dir3[l];
        dval4[l] <= dval3[l];
        sg4[l] <= sg3[l];
        mag4[l] <= mag4_next[l];
        pos4[l] <= pos4_next[l];
      end
    end
  end

  `ASSERT_CLK(a_stall_blocks_req, (res_valid && !res_ready) |-> !req_ready, "request taken during stall")
  `ASSERT_CLK(a_stage4_holds, (v4 && !adv) |=> v4, "stage 4 lost a request during stall")
  `ASSERT_ALWAYS(a_reset_clears, rst |=> (!res_valid && !v1 && !v4), "valid bits survive reset")

endmodule

`default_nettype wire

>>> bench/tb_top.sv
// Self-checking bench for noc_collective_reduction_lanes_core: drives requests,
// predicts each result lane by lane and checks it in order. Depends on ncrl_pkg.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ncrl_pkg::*;

  localparam int STALL_LIMIT = 4000;

  logic      clk;
  logic      rst;
  logic      req_valid;
  logic      req_ready;
  ncrl_req_t req;
  logic      res_valid;
  logic      res_ready;
  ncrl_res_t res;

  int        mismatches = 0;
  int        tx_idle_pct = 0;
  int        rx_idle_pct = 0;
  int        quiet_cycles = 0;

  noc_collective_reduction_lanes_core DUT (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .res_valid(res_valid), .res_ready(res_ready), .res(res)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // Widened fp16 magnitude in units of 2^-136; exact unless the exponent is 0.
  function automatic logic [159:0] half_mag(input logic [15:0] h);
    logic [159:0] v;
    v = 160'(h[9:0]);
    if (h[14:10] != 5'd0) begin
      v = 160'(11'd1024 + h[9:0]) << (h[14:10] + 111);
    end
    return v;
  endfunction

  function automatic bit half_gt(input logic [15:0] a, input logic [15:0] c);
    logic [159:0] ma, mc;
    ma = half_mag(a);
    mc = half_mag(c);
    if (ma == 0 && mc == 0) return 1'b0;
    if (a[15] != c[15]) return !a[15];
    return a[15] ? (ma < mc) : (ma > mc);
  endfunction

  // Round to single precision, then narrow with the block's truncating rules.
  function automatic logic [15:0] narrow_mag(input logic sgn, input logic [159:0] mag);
    int p, sh, x;
    logic [24:0] mant;
    logic guard, sticky;
    p = -1;
    for (int i = 159; i >= 0; i--) begin
      if (p < 0 && mag[i]) p = i;
    end
    if (p < 0) return {sgn, 15'd0};
    if (p > 23) begin
      sh = p - 23;
      mant = 25'(mag >> sh);
      guard = mag[sh-1];
      sticky = (mag & ((160'(1) << (sh - 1)) - 1)) != 0;
      if (guard && (sticky || mant[0])) mant = mant + 1;
      if (mant[24]) begin
        mant = mant >> 1;
        p++;
      end
    end else begin
      mant = 25'(mag << (23 - p));
    end
    x = p - 121;
    if (x < -10) return {sgn, 15'd0};
    if (x <= 0) return {sgn, 15'(24'(mant) >> (14 - x))};
    if (x >= 31) return {sgn, HALF_INF};
    return {sgn, 5'(x), mant[22:13]};
  endfunction

  function automatic logic [15:0] reduce_lane(input logic [2:0] cmd,
                                              input logic [15:0] a, input logic [15:0] c);
    logic [159:0] ma, mc;
    case (cmd)
      CMD_UADD, CMD_SADD: return a + c;
      CMD_UMAX: return (a > c) ? a : c;
      CMD_SMAX: return ($signed(a) > $signed(c)) ? a : c;
      CMD_FMAX: begin
        if (half_gt(a, c)) return narrow_mag(a[15], half_mag(a));
        return narrow_mag(c[15], half_mag(c));
      end
      CMD_FADD: begin
        ma = half_mag(a);
        mc = half_mag(c);
        if (a[15] == c[15]) return narrow_mag(a[15], ma + mc);
        if (ma > mc) return narrow_mag(a[15], ma - mc);
        if (mc > ma) return narrow_mag(c[15], mc - ma);
        return 16'h0000;
      end
      default: return a;
    endcase
  endfunction

  class reduction_scoreboard;
    ncrl_res_t pending[$];

    function void note_request(ncrl_req_t r);
      ncrl_res_t e;
      e.res_lane0 = reduce_lane(r.cmd, r.acc_lane0, r.child_lane0);
      e.res_lane1 = reduce_lane(r.cmd, r.acc_lane1, r.child_lane1);
      e.res_lane2 = reduce_lane(r.cmd, r.acc_lane2, r.child_lane2);
      e.res_lane3 = reduce_lane(r.cmd, r.acc_lane3, r.child_lane3);
      e.unknown_op = (r.cmd == CMD_UNKNOWN);
      pending.push_back(e);
    endfunction

    task check_result(ncrl_res_t got);
      ncrl_res_t e;
      if (pending.size() == 0) begin
        report("unexpected result", int'(got.res_lane0), 0);
        return;
      end
      e = pending.pop_front();
      if (got.res_lane0 !== e.res_lane0) begin
        report("res_lane0", int'(got.res_lane0), int'(e.res_lane0));
      end
      if (got.res_lane1 !== e.res_lane1) begin
        report("res_lane1", int'(got.res_lane1), int'(e.res_lane1));
      end
      if (got.res_lane2 !== e.res_lane2) begin
        report("res_lane2", int'(got.res_lane2), int'(e.res_lane2));
      end
      if (got.res_lane3 !== e.res_lane3) begin
        report("res_lane3", int'(got.res_lane3), int'(e.res_lane3));
      end
      if (got.unknown_op !== e.unknown_op) begin
        report("unknown_op", int'(got.unknown_op), int'(e.unknown_op));
      end
    endtask
  endclass

  reduction_scoreboard sb = new();

  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && req_ready) sb.note_request(req);
      if (res_valid && res_ready) sb.check_result(res);
      if ((req_valid && req_ready) || (res_valid && res_ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("[noc_collective_reduction_lanes_core] ERROR");
        $finish;
      end
    end
  end

  always @(posedge clk) begin
    res_ready <= !rst && ($urandom_range(99) >= rx_idle_pct);
  end

  // Holds valid until the request is taken, then maybe leaves a gap.
  task automatic send_request(input ncrl_req_t r);
    int gap;
    req <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct && gap < 8) gap++;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic ncrl_req_t make_request(input logic [2:0] cmd, input logic [15:0] a0,
                                             input logic [15:0] a1, input logic [15:0] a2,
                                             input logic [15:0] a3, input logic [15:0] c0,
                                             input logic [15:0] c1, input logic [15:0] c2,
                                             input logic [15:0] c3);
    return '{cmd, a0, a1, a2, a3, c0, c1, c2, c3};
  endfunction

  // Mostly random lanes, with a share of fp16 and integer edge values.
  function automatic logic [15:0] pick_lane();
    logic [15:0] edge_vals[12] = '{16'h0000, 16'h8000, 16'hFFFF, 16'h7FFF, 16'h7C00,
                                   16'hFC00, 16'h0001, 16'h0400, 16'h3C00, 16'hBC00,
                                   16'h7BFF, 16'h03FF};
    if ($urandom_range(3) == 0) return edge_vals[$urandom_range(11)];
    return 16'($urandom());
  endfunction

  task automatic send_random(input int count);
    for (int i = 0; i < count; i++) begin
      send_request(make_request(3'($urandom_range(7)), pick_lane(), pick_lane(), pick_lane(),
                                pick_lane(), pick_lane(), pick_lane(), pick_lane(),
                                pick_lane()));
    end
  endtask

  initial begin
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    res_ready = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    tx_idle_pct = 12;
    rx_idle_pct = 57;

    // Directed: every command on integer extremes, then fp16 corner cases.
    for (int k = 0; k < 8; k++) begin
      send_request(make_request(3'(k), 16'h0000, 16'hFFFF, 16'h7FFF, 16'h8000,
                                16'hFFFF, 16'hFFFF, 16'h8000, 16'h8000));
    end
    send_request(make_request(CMD_SMAX, 16'h1234, 16'h8000, 16'hFFFF, 16'h0000,
                              16'h1234, 16'h7FFF, 16'h0001, 16'hFFFF));
    // Exponent 31 is finite; lanes 0-2 overflow to infinity, lane 3 cancels.
    send_request(make_request(CMD_FADD, 16'h7C00, 16'hFC00, 16'h7BFF, 16'h7FFF,
                              16'h7C00, 16'hFC00, 16'h7BFF, 16'hFFFF));
    // Zeros of either sign, exact cancellation and tiny exponent-zero inputs.
    send_request(make_request(CMD_FADD, 16'h8000, 16'h0000, 16'h3C00, 16'h03FF,
                              16'h8000, 16'h8000, 16'hBC00, 16'h0001));
    // Sums near the fp16 subnormal range; some land in it or underflow to zero.
    send_request(make_request(CMD_FADD, 16'h0400, 16'h0401, 16'h0010, 16'h1400,
                              16'h8200, 16'h8400, 16'h8001, 16'h9000));
    send_request(make_request(CMD_FADD, 16'h3C00, 16'h3C01, 16'h7800, 16'h0000,
                              16'h1000, 16'h0C01, 16'h7800, 16'h03FF));
    send_request(make_request(CMD_FMAX, 16'h0000, 16'h8000, 16'h7C00, 16'h03FF,
                              16'h8000, 16'h0000, 16'h7BFF, 16'h0400));
    send_request(make_request(CMD_FMAX, 16'hFC00, 16'h3C00, 16'h0001, 16'h0200,
                              16'hFBFF, 16'h3C00, 16'h8001, 16'h0400));

    send_random(420);
    // Let the pipeline drain completely before going on.
    req_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    tx_idle_pct = 57;
    rx_idle_pct = 12;
    send_random(420);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    send_random(440);
    req_valid <= 1'b0;
    @(posedge clk);

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("[noc_collective_reduction_lanes_core] OK");
    end else begin
      $display("[noc_collective_reduction_lanes_core] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
